[design/hse_pkg.sv]
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types, constants and codes for the histogram selectivity estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package hse_pkg;

  localparam int MAX_BUCKETS_DEF = 64;
  localparam int VALUE_BITS_DEF  = 32;

  // Q1.16 constants
  localparam logic [16:0] Q_ONE  = 17'd65536;
  localparam logic [16:0] Q_P01  = 17'd655;
  localparam logic [16:0] Q_P99  = 17'd64881;
  localparam logic [16:0] Q_P33  = 17'd21627;
  localparam logic [16:0] Q_HALF = 17'd32768;

  // configuration register indexes
  localparam logic CFG_BUCKET_COUNT = 1'b0;
  localparam logic CFG_DISTINCT     = 1'b1;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    OP_EQ    = 3'd0,
    OP_NE    = 3'd1,
    OP_LT    = 3'd2,
    OP_LE    = 3'd3,
    OP_GT    = 3'd4,
    OP_GE    = 3'd5,
    OP_RANGE = 3'd6,
    OP_DIST  = 3'd7
  } op_t;

  typedef struct packed {
    logic               req_type;
    logic [6:0]         bound_slot;
    logic signed [31:0] bound_word;
    logic [2:0]         predicate_op;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
  } in_t;

  typedef struct packed {
    logic [16:0] selectivity;
    logic [31:0] distinct_estimate;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_L_INIT,
    S_L_B0,
    S_L_BN,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SRCH,
    S_SRCH_MID,
    S_SRCH_MID1,
    S_PART,
    S_PART_LO,
    S_PART_HI,
    S_FRAC,
    S_DGO,
    S_L_DIV,
    S_E_INIT,
    S_E_B0,
    S_E_BN,
    S_E_DIV,
    S_FIN,
    S_MUL,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    A_ZERO, A_N, A_IP1, A_MID, A_MID1, A_B, A_B1
  } addr_t;

  typedef enum logic [1:0] { PICK_NONE, PICK_A, PICK_B } pick_t;
  typedef enum logic [1:0] { L_HALF, L_ZERO, L_ONE, L_DIV } l_src_t;
  typedef enum logic [1:0] { E_P01, E_ZERO, E_DIV } e_src_t;
  typedef enum logic [1:0] { P_ZERO, P_ONE, P_FRAC } p_src_t;

  typedef struct packed {
    logic   wr_bound;
    logic   accept_q;
    pick_t  pick;
    addr_t  addr;
    logic   l_wr;
    l_src_t l_src;
    logic   e_wr;
    e_src_t e_src;
    logic   p_wr;
    p_src_t p_src;
    logic   scan_init;
    logic   scan_inc;
    logic   srch_init;
    logic   set_hi_mid;
    logic   set_lo_mid1;
    logic   set_lo_mid;
    logic   cap_lo;
    logic   frac_start;
    logic   div_start_l;
    logic   div_start_e;
    logic   fin;
    logic   mul;
    logic   out_strobe;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic need_lb;
    logic need_la;
    logic need_e;
    logic skip;
    logic no_data;
    logic d_zero;
    logic v_le_rd;
    logic v_lt_rd;
    logic scan_end;
    logic lo_lt_hi;
    logic b_lt_n;
    logic hi_gt_lo;
    logic v_le_lo;
    logic v_ge_hi;
    logic frac_busy;
    logic div_busy;
  } sts_t;

endpackage

`default_nettype wire

[design/hse_ram.sv]
// ----------------------------------------------------------------------------
// hse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_ram #(
  parameter int W = 32,
  parameter int D = 65
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/hse_ctrl.sv]
// ----------------------------------------------------------------------------
// hse_ctrl
// Sequencer: bound search, partial fraction, divisions and result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire hse_pkg::sts_t sts,
  output logic               busy,
  output hse_pkg::cmd_t      cmd
);

  hse_pkg::state_t state_r, state_nxt;
  logic            l_done;
  logic            lb_phase;
  logic            cur_is_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hse_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != hse_pkg::S_IDLE);

  // first L of a range query works on the high end
  assign lb_phase = l_done && cur_is_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_is_b_r <= 1'b0;
    end else if (cmd.pick == hse_pkg::PICK_A) begin
      cur_is_b_r <= 1'b0;
    end else if (cmd.pick == hse_pkg::PICK_B) begin
      cur_is_b_r <= 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hse_pkg::S_IDLE: begin
        if (start && sts.is_query) begin
          if (sts.skip) state_nxt = hse_pkg::S_FIN;
          else if (sts.need_lb || sts.need_la) state_nxt = hse_pkg::S_L_INIT;
          else state_nxt = hse_pkg::S_E_INIT;
        end
      end
      hse_pkg::S_L_INIT: state_nxt = sts.no_data ? hse_pkg::S_FIN : hse_pkg::S_L_B0;
      hse_pkg::S_L_B0:   state_nxt = sts.v_le_rd ? hse_pkg::S_FIN : hse_pkg::S_L_BN;
      hse_pkg::S_L_BN:   state_nxt = !sts.v_le_rd ? hse_pkg::S_FIN : hse_pkg::S_SCAN_RD;
      hse_pkg::S_SCAN_RD: state_nxt = hse_pkg::S_SCAN_CHK;
      hse_pkg::S_SCAN_CHK: begin
        if (sts.v_lt_rd || sts.scan_end) state_nxt = hse_pkg::S_SRCH;
        else state_nxt = hse_pkg::S_SCAN_RD;
      end
      hse_pkg::S_SRCH: state_nxt = sts.lo_lt_hi ? hse_pkg::S_SRCH_MID : hse_pkg::S_PART;
      hse_pkg::S_SRCH_MID: state_nxt = sts.v_lt_rd ? hse_pkg::S_SRCH : hse_pkg::S_SRCH_MID1;
      hse_pkg::S_SRCH_MID1: state_nxt = !sts.v_lt_rd ? hse_pkg::S_SRCH : hse_pkg::S_PART;
      hse_pkg::S_PART:    state_nxt = sts.b_lt_n ? hse_pkg::S_PART_LO : hse_pkg::S_DGO;
      hse_pkg::S_PART_LO: state_nxt = hse_pkg::S_PART_HI;
      hse_pkg::S_PART_HI: begin
        if (sts.hi_gt_lo && !sts.v_le_lo && !sts.v_ge_hi) state_nxt = hse_pkg::S_FRAC;
        else state_nxt = hse_pkg::S_DGO;
      end
      hse_pkg::S_FRAC:  state_nxt = sts.frac_busy ? hse_pkg::S_FRAC : hse_pkg::S_DGO;
      hse_pkg::S_DGO:   state_nxt = hse_pkg::S_L_DIV;
      hse_pkg::S_L_DIV: state_nxt = sts.div_busy ? hse_pkg::S_L_DIV : hse_pkg::S_FIN;
      hse_pkg::S_E_INIT: state_nxt = (sts.no_data || sts.d_zero) ? hse_pkg::S_FIN
                                                                 : hse_pkg::S_E_B0;
      hse_pkg::S_E_B0: state_nxt = sts.v_lt_rd ? hse_pkg::S_FIN : hse_pkg::S_E_BN;
      hse_pkg::S_E_BN: state_nxt = !sts.v_le_rd ? hse_pkg::S_FIN : hse_pkg::S_E_DIV;
      hse_pkg::S_E_DIV: state_nxt = sts.div_busy ? hse_pkg::S_E_DIV : hse_pkg::S_FIN;
      hse_pkg::S_FIN: state_nxt = hse_pkg::S_MUL;
      hse_pkg::S_MUL: state_nxt = hse_pkg::S_OUT;
      hse_pkg::S_OUT: state_nxt = hse_pkg::S_IDLE;
      default:        state_nxt = hse_pkg::S_IDLE;
    endcase
    // an L figure just finished: second operand, equality, or combine
    if (state_nxt == hse_pkg::S_FIN && state_r != hse_pkg::S_IDLE
        && state_r != hse_pkg::S_E_INIT && state_r != hse_pkg::S_E_B0
        && state_r != hse_pkg::S_E_BN && state_r != hse_pkg::S_E_DIV) begin
      if (cmd.pick == hse_pkg::PICK_A && sts.need_lb && sts.need_la && lb_phase)
        state_nxt = hse_pkg::S_L_INIT;
      else if (sts.need_e)
        state_nxt = hse_pkg::S_E_INIT;
    end
  end

  // outputs
  always_comb begin
    cmd    = '0;
    l_done = 1'b0;
    case (state_r)
      hse_pkg::S_IDLE: begin
        if (start && !sts.is_query) cmd.wr_bound = 1'b1;
        if (start && sts.is_query) begin
          cmd.accept_q = 1'b1;
          cmd.pick     = sts.need_lb ? hse_pkg::PICK_B : hse_pkg::PICK_A;
        end
      end
      hse_pkg::S_L_INIT: begin
        cmd.addr = hse_pkg::A_ZERO;
        if (sts.no_data) begin
          cmd.l_wr = 1'b1; cmd.l_src = hse_pkg::L_HALF; l_done = 1'b1;
        end
      end
      hse_pkg::S_L_B0: begin
        cmd.addr = hse_pkg::A_N;
        if (sts.v_le_rd) begin
          cmd.l_wr = 1'b1; cmd.l_src = hse_pkg::L_ZERO; l_done = 1'b1;
        end
      end
      hse_pkg::S_L_BN: begin
        if (!sts.v_le_rd) begin
          cmd.l_wr = 1'b1; cmd.l_src = hse_pkg::L_ONE; l_done = 1'b1;
        end else begin
          cmd.scan_init = 1'b1;
        end
      end
      hse_pkg::S_SCAN_RD: cmd.addr = hse_pkg::A_IP1;
      hse_pkg::S_SCAN_CHK: begin
        if (!sts.v_lt_rd) cmd.scan_inc = 1'b1;
        if (sts.v_lt_rd || sts.scan_end) cmd.srch_init = 1'b1;
      end
      hse_pkg::S_SRCH: cmd.addr = hse_pkg::A_MID;
      hse_pkg::S_SRCH_MID: begin
        cmd.addr = hse_pkg::A_MID1;
        if (sts.v_lt_rd) cmd.set_hi_mid = 1'b1;
      end
      hse_pkg::S_SRCH_MID1: begin
        if (!sts.v_lt_rd) cmd.set_lo_mid1 = 1'b1;
        else cmd.set_lo_mid = 1'b1;
      end
      hse_pkg::S_PART: begin
        cmd.addr = hse_pkg::A_B;
        if (!sts.b_lt_n) begin
          cmd.p_wr = 1'b1; cmd.p_src = hse_pkg::P_ZERO;
        end
      end
      hse_pkg::S_PART_LO: begin
        cmd.addr   = hse_pkg::A_B1;
        cmd.cap_lo = 1'b1;
      end
      hse_pkg::S_PART_HI: begin
        if (!sts.hi_gt_lo || sts.v_le_lo) begin
          cmd.p_wr = 1'b1; cmd.p_src = hse_pkg::P_ZERO;
        end else if (sts.v_ge_hi) begin
          cmd.p_wr = 1'b1; cmd.p_src = hse_pkg::P_ONE;
        end else begin
          cmd.frac_start = 1'b1;
        end
      end
      hse_pkg::S_FRAC: begin
        if (!sts.frac_busy) begin
          cmd.p_wr = 1'b1; cmd.p_src = hse_pkg::P_FRAC;
        end
      end
      hse_pkg::S_DGO: cmd.div_start_l = 1'b1;
      hse_pkg::S_L_DIV: begin
        if (!sts.div_busy) begin
          cmd.l_wr = 1'b1; cmd.l_src = hse_pkg::L_DIV; l_done = 1'b1;
        end
      end
      hse_pkg::S_E_INIT: begin
        cmd.addr = hse_pkg::A_ZERO;
        if (sts.no_data || sts.d_zero) begin
          cmd.e_wr = 1'b1; cmd.e_src = hse_pkg::E_P01;
        end
      end
      hse_pkg::S_E_B0: begin
        cmd.addr = hse_pkg::A_N;
        if (sts.v_lt_rd) begin
          cmd.e_wr = 1'b1; cmd.e_src = hse_pkg::E_ZERO;
        end
      end
      hse_pkg::S_E_BN: begin
        if (!sts.v_le_rd) begin
          cmd.e_wr = 1'b1; cmd.e_src = hse_pkg::E_ZERO;
        end else begin
          cmd.div_start_e = 1'b1;
        end
      end
      hse_pkg::S_E_DIV: begin
        if (!sts.div_busy) begin
          cmd.e_wr = 1'b1; cmd.e_src = hse_pkg::E_DIV;
        end
      end
      hse_pkg::S_FIN: cmd.fin = 1'b1;
      hse_pkg::S_MUL: cmd.mul = 1'b1;
      hse_pkg::S_OUT: cmd.out_strobe = 1'b1;
      default: ;
    endcase
    // leaving an L figure always moves to operand a
    if (l_done) cmd.pick = hse_pkg::PICK_A;
  end

endmodule

`default_nettype wire

[design/hse_dpath.sv]
// ----------------------------------------------------------------------------
// hse_dpath
// Datapath: bound store, search registers, fraction and quotient units.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_dpath #(
  parameter int MAX_BUCKETS = hse_pkg::MAX_BUCKETS_DEF,
  parameter int VALUE_BITS  = hse_pkg::VALUE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire hse_pkg::in_t  in_item,
  input  wire hse_pkg::cmd_t cmd,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [31:0]   cfg_data,
  output hse_pkg::sts_t      sts,
  output hse_pkg::out_t      out_item
);

  localparam int AW   = $clog2(MAX_BUCKETS + 1);
  localparam int VB   = VALUE_BITS;
  localparam int EXT  = (VB > 32) ? VB : 32;
  localparam int NUMW = AW + 17;
  localparam int DCW  = $clog2(NUMW + 1);

  // configuration
  logic [6:0]  bc_r, bc_nxt;
  logic [31:0] d_r, d_nxt;
  logic [AW-1:0] n;

  assign n = (32'(bc_r) > 32'(MAX_BUCKETS)) ? AW'(MAX_BUCKETS) : AW'(bc_r);

  // keys: signed value to order-preserving unsigned
  logic signed [EXT-1:0] ext_a, ext_b, ext_w;
  logic [VB-1:0] key_a, key_b, key_w;
  assign ext_a = EXT'(in_item.value_a);
  assign ext_b = EXT'(in_item.value_b);
  assign ext_w = EXT'(in_item.bound_word);
  assign key_a = {~ext_a[VB-1], ext_a[VB-2:0]};
  assign key_b = {~ext_b[VB-1], ext_b[VB-2:0]};
  assign key_w = {~ext_w[VB-1], ext_w[VB-2:0]};

  // query registers
  logic [2:0]    op_r, op_nxt;
  logic [VB-1:0] ka_r, ka_nxt, kb_r, kb_nxt, v;
  logic          cur_b_r, cur_b_nxt;
  logic [AW-1:0] full_r, full_nxt, i_r, i_nxt, lo_r, lo_nxt, hi_r, hi_nxt, mid;
  logic [VB-1:0] lo_val_r, lo_val_nxt;
  logic [16:0]   p_r, p_nxt, la_r, la_nxt, lb_r, lb_nxt, e_r, e_nxt, sel_r, sel_nxt;
  logic [48:0]   prod_r, prod_nxt;

  // fraction unit
  logic [VB-1:0] fr_r, fr_nxt, fden_r, fden_nxt;
  logic [15:0]   fq_r, fq_nxt;
  logic [4:0]    fcnt_r, fcnt_nxt;
  logic          fbusy_r, fbusy_nxt;
  logic [VB:0]   f_sh;
  logic          f_ge;

  // quotient unit
  logic [31:0]     drem_r, drem_nxt, dden_r, dden_nxt;
  logic [NUMW-1:0] dq_r, dq_nxt;
  logic [DCW-1:0]  dcnt_r, dcnt_nxt;
  logic            dbusy_r, dbusy_nxt;
  logic [32:0]     d_sh, d_diff;
  logic            d_ge;
  logic [16:0]     l_quot;

  // store
  logic          ram_we;
  logic [AW-1:0] raddr;
  logic [VB-1:0] rdata;

  assign ram_we = cmd.wr_bound && (32'(in_item.bound_slot) <= 32'(MAX_BUCKETS));

  hse_ram #(.W(VB), .D(MAX_BUCKETS + 1)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_item.bound_slot)),
    .wdata (key_w),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign mid = AW'(((AW + 1)'(lo_r) + (AW + 1)'(hi_r)) >> 1);
  assign v   = cur_b_r ? kb_r : ka_r;

  always_comb begin
    case (cmd.addr)
      hse_pkg::A_ZERO: raddr = '0;
      hse_pkg::A_N:    raddr = n;
      hse_pkg::A_IP1:  raddr = i_r + AW'(1);
      hse_pkg::A_MID:  raddr = mid;
      hse_pkg::A_MID1: raddr = mid + AW'(1);
      hse_pkg::A_B:    raddr = lo_r;
      hse_pkg::A_B1:   raddr = lo_r + AW'(1);
      default:         raddr = '0;
    endcase
  end

  // status
  always_comb begin
    sts           = '0;
    sts.is_query  = (in_item.req_type == hse_pkg::REQ_QUERY);
    sts.need_lb   = op_nxt inside {hse_pkg::OP_RANGE, hse_pkg::OP_DIST};
    sts.need_la   = op_nxt inside {hse_pkg::OP_LT, hse_pkg::OP_LE, hse_pkg::OP_GT,
                                   hse_pkg::OP_GE, hse_pkg::OP_RANGE, hse_pkg::OP_DIST};
    sts.need_e    = op_nxt inside {hse_pkg::OP_EQ, hse_pkg::OP_NE, hse_pkg::OP_LE,
                                   hse_pkg::OP_GT};
    sts.no_data   = (n == '0);
    sts.skip      = sts.no_data && !sts.need_lb;
    sts.d_zero    = (d_r == '0);
    sts.v_le_rd   = (v <= rdata);
    sts.v_lt_rd   = (v < rdata);
    sts.scan_end  = ((i_r + AW'(1)) == n);
    sts.lo_lt_hi  = (lo_r < hi_r);
    sts.b_lt_n    = (lo_r < n);
    sts.hi_gt_lo  = (rdata > lo_val_r);
    sts.v_le_lo   = (v <= lo_val_r);
    sts.v_ge_hi   = (v >= rdata);
    sts.frac_busy = fbusy_r;
    sts.div_busy  = dbusy_r;
  end

  // op seen at the accept edge, so the controller can branch straight away
  always_comb begin
    op_nxt = cmd.accept_q ? in_item.predicate_op : op_r;
  end

  assign f_sh   = {fr_r, 1'b0};
  assign f_ge   = (f_sh >= {1'b0, fden_r});
  assign d_sh   = {drem_r, dq_r[NUMW-1]};
  assign d_ge   = (d_sh >= {1'b0, dden_r});
  assign d_diff = d_sh - {1'b0, dden_r};
  assign l_quot = (dq_r > NUMW'(hse_pkg::Q_ONE)) ? hse_pkg::Q_ONE : dq_r[16:0];

  always_comb begin
    logic [17:0] s;
    bc_nxt     = bc_r;
    d_nxt      = d_r;
    ka_nxt     = ka_r;
    kb_nxt     = kb_r;
    cur_b_nxt  = cur_b_r;
    full_nxt   = full_r;
    i_nxt      = i_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    lo_val_nxt = lo_val_r;
    p_nxt      = p_r;
    la_nxt     = la_r;
    lb_nxt     = lb_r;
    e_nxt      = e_r;
    sel_nxt    = sel_r;
    prod_nxt   = prod_r;
    fr_nxt     = fr_r;
    fden_nxt   = fden_r;
    fq_nxt     = fq_r;
    fcnt_nxt   = fcnt_r;
    fbusy_nxt  = fbusy_r;
    drem_nxt   = drem_r;
    dden_nxt   = dden_r;
    dq_nxt     = dq_r;
    dcnt_nxt   = dcnt_r;
    dbusy_nxt  = dbusy_r;
    s          = '0;

    if (cfg_we) begin
      if (cfg_index == hse_pkg::CFG_BUCKET_COUNT) bc_nxt = cfg_data[6:0];
      else d_nxt = cfg_data;
    end

    if (cmd.accept_q) begin
      ka_nxt = key_a;
      kb_nxt = key_b;
    end
    if (cmd.pick == hse_pkg::PICK_A) cur_b_nxt = 1'b0;
    else if (cmd.pick == hse_pkg::PICK_B) cur_b_nxt = 1'b1;

    if (cmd.scan_init) begin
      full_nxt = '0;
      i_nxt    = '0;
    end
    if (cmd.scan_inc) begin
      full_nxt = full_r + AW'(1);
      i_nxt    = i_r + AW'(1);
    end
    if (cmd.srch_init) begin
      lo_nxt = '0;
      hi_nxt = n;
    end
    if (cmd.set_hi_mid)  hi_nxt = mid;
    if (cmd.set_lo_mid1) lo_nxt = mid + AW'(1);
    if (cmd.set_lo_mid)  lo_nxt = mid;
    if (cmd.cap_lo)      lo_val_nxt = rdata;

    // partial bucket fraction, one quotient bit a cycle
    if (cmd.frac_start) begin
      fr_nxt    = v - lo_val_r;
      fden_nxt  = rdata - lo_val_r;
      fq_nxt    = '0;
      fcnt_nxt  = 5'd16;
      fbusy_nxt = 1'b1;
    end else if (fbusy_r) begin
      fr_nxt    = f_ge ? VB'(f_sh - {1'b0, fden_r}) : f_sh[VB-1:0];
      fq_nxt    = {fq_r[14:0], f_ge};
      fcnt_nxt  = fcnt_r - 5'd1;
      fbusy_nxt = (fcnt_r != 5'd1);
    end

    if (cmd.p_wr) begin
      case (cmd.p_src)
        hse_pkg::P_ZERO: p_nxt = '0;
        hse_pkg::P_ONE:  p_nxt = hse_pkg::Q_ONE;
        hse_pkg::P_FRAC: p_nxt = {1'b0, fq_r};
        default:         p_nxt = '0;
      endcase
    end

    // shared restoring divider
    if (cmd.div_start_l || cmd.div_start_e) begin
      drem_nxt  = '0;
      dden_nxt  = cmd.div_start_l ? 32'(n) : d_r;
      dq_nxt    = cmd.div_start_l ? ((NUMW'(full_r) << 16) + NUMW'(p_r))
                                  : NUMW'(hse_pkg::Q_ONE);
      dcnt_nxt  = DCW'(NUMW);
      dbusy_nxt = 1'b1;
    end else if (dbusy_r) begin
      drem_nxt  = d_ge ? d_diff[31:0] : d_sh[31:0];
      dq_nxt    = {dq_r[NUMW-2:0], d_ge};
      dcnt_nxt  = dcnt_r - DCW'(1);
      dbusy_nxt = (dcnt_r != DCW'(1));
    end

    if (cmd.l_wr) begin
      case (cmd.l_src)
        hse_pkg::L_HALF: s[16:0] = hse_pkg::Q_HALF;
        hse_pkg::L_ZERO: s[16:0] = '0;
        hse_pkg::L_ONE:  s[16:0] = hse_pkg::Q_ONE;
        hse_pkg::L_DIV:  s[16:0] = l_quot;
        default:         s[16:0] = '0;
      endcase
      if (cur_b_r) lb_nxt = s[16:0];
      else la_nxt = s[16:0];
    end

    if (cmd.e_wr) begin
      case (cmd.e_src)
        hse_pkg::E_P01:  e_nxt = hse_pkg::Q_P01;
        hse_pkg::E_ZERO: e_nxt = '0;
        hse_pkg::E_DIV:  e_nxt = dq_r[16:0];
        default:         e_nxt = '0;
      endcase
    end

    if (cmd.fin) begin
      if (sts.skip) begin
        case (op_r)
          hse_pkg::OP_EQ: sel_nxt = hse_pkg::Q_P01;
          hse_pkg::OP_NE: sel_nxt = hse_pkg::Q_P99;
          default:        sel_nxt = hse_pkg::Q_P33;
        endcase
      end else begin
        s = {1'b0, la_r} + {1'b0, e_r};
        case (op_r)
          hse_pkg::OP_EQ: sel_nxt = e_r;
          hse_pkg::OP_NE: sel_nxt = hse_pkg::Q_ONE - e_r;
          hse_pkg::OP_LT: sel_nxt = la_r;
          hse_pkg::OP_LE: sel_nxt = (s > 18'(hse_pkg::Q_ONE)) ? hse_pkg::Q_ONE : s[16:0];
          hse_pkg::OP_GT: sel_nxt = (s < 18'(hse_pkg::Q_ONE))
                                    ? 17'(18'(hse_pkg::Q_ONE) - s) : 17'd0;
          hse_pkg::OP_GE: sel_nxt = hse_pkg::Q_ONE - la_r;
          default:        sel_nxt = (lb_r > la_r) ? (lb_r - la_r) : 17'd0;
        endcase
      end
    end

    if (cmd.mul) prod_nxt = 49'(sel_r) * 49'(d_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r    <= '0;
      d_r     <= '0;
      op_r    <= '0;
      cur_b_r <= 1'b0;
      fbusy_r <= 1'b0;
      dbusy_r <= 1'b0;
    end else begin
      bc_r    <= bc_nxt;
      d_r     <= d_nxt;
      op_r    <= op_nxt;
      cur_b_r <= cur_b_nxt;
      fbusy_r <= fbusy_nxt;
      dbusy_r <= dbusy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ka_r     <= ka_nxt;
    kb_r     <= kb_nxt;
    full_r   <= full_nxt;
    i_r      <= i_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    lo_val_r <= lo_val_nxt;
    p_r      <= p_nxt;
    la_r     <= la_nxt;
    lb_r     <= lb_nxt;
    e_r      <= e_nxt;
    sel_r    <= sel_nxt;
    prod_r   <= prod_nxt;
    fr_r     <= fr_nxt;
    fden_r   <= fden_nxt;
    fq_r     <= fq_nxt;
    fcnt_r   <= fcnt_nxt;
    drem_r   <= drem_nxt;
    dden_r   <= dden_nxt;
    dq_r     <= dq_nxt;
    dcnt_r   <= dcnt_nxt;
  end

  always_comb begin
    out_item.selectivity       = sel_r;
    out_item.distinct_estimate = '0;
    if (op_r == hse_pkg::OP_DIST && d_r != '0) begin
      out_item.distinct_estimate = (prod_r[47:16] == '0) ? 32'd1 : prod_r[47:16];
    end
  end

endmodule

`default_nettype wire

[design/histogram_selectivity_estimator_core.sv]
// ----------------------------------------------------------------------------
// histogram_selectivity_estimator_core
// Predicate selectivity from an equi-height histogram, Q1.16 result.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low. A bound write
// lands in the bound store at the accepting edge, gives no result and leaves
// busy low. A query raises busy and, when done, puts one result on out_item
// with out_valid high for exactly one cycle; there is no back-pressure, so
// the receiver must take it then. A less-than figure (range queries need
// two) is dominated by the linear scan over bucket bounds, followed by a
// binary search, a fraction divider and a quotient divider. An equality
// figure comes after any less-than figures; combining, scaling and the strobe
// come last. Configuration (cfg_valid/cfg_ready, always ready) must only be
// written while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_selectivity_estimator_core #(
  parameter int MAX_BUCKETS = hse_pkg::MAX_BUCKETS_DEF,
  parameter int VALUE_BITS  = hse_pkg::VALUE_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire hse_pkg::in_t in_item,
  output logic              out_valid,
  output hse_pkg::out_t     out_item,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_data
);

  hse_pkg::cmd_t cmd;
  hse_pkg::sts_t sts;

  // registers are plain flops: writes never stall
  assign cfg_ready = 1'b1;
  assign out_valid = cmd.out_strobe;

  hse_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  hse_dpath #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .out_item  (out_item)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.selectivity <= 17'd65536))
    else $error("selectivity above one");

  a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");

endmodule

`default_nettype wire
